// ===== sv/url_percent_decoder_defines.svh =====
// Assertion macros shared by the URL percent decoder RTL.
`ifndef URL_PERCENT_DECODER_DEFINES_SVH
`define URL_PERCENT_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while in reset.
`define UPD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define UPD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define UPD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define UPD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== sv/upd_pkg.sv =====
// Types, character codes and helpers shared by the URL percent decoder.
package upd_pkg;

	localparam int LEN_W = 12;
	localparam logic [LEN_W-1:0] LEN_RESET = 12'hFFF;

	localparam int GQ_DEPTH = 4;
	localparam int GQ_AW = 2;

	localparam logic [7:0] CHR_PCT = 8'h25;
	localparam logic [7:0] CHR_PLUS = 8'h2B;
	localparam logic [7:0] CHR_SPACE = 8'h20;

	typedef enum logic [1:0] {
		PH_NONE,
		PH_PCT,
		PH_DIGIT
	} phase_t;

	typedef struct packed {
		logic ok;
		logic [3:0] val;
	} hex_t;

	// One accepted request's worth of results, up to three bytes.
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0] num;
		logic has_byte;
		logic last;
		logic trunc;
	} group_t;

	function automatic hex_t hex_digit(input logic [7:0] c);
		hex_t h;
		h.ok = 1'b1;
		h.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.val = c[3:0];
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.val = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.val = 4'(c - 8'h37);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

// ===== sv/upd_front.sv =====
// Front end: escape tracking, candidate bytes, length limit and config register.
module upd_front #(
	parameter int COUNT_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [7:0]                    in_byte,
	input  logic                          in_last,
	input  logic                          cfg_valid,
	input  logic [upd_pkg::LEN_W-1:0]     cfg_data,
	output logic                          gq_push,
	output upd_pkg::group_t               gq_wr
);
	import upd_pkg::*;

	localparam int CMP_W = ((COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W) + 1;
	localparam logic [CMP_W-1:0] CNT_MAX = CMP_W'((64'd1 << COUNT_BITS) - 64'd1);

	logic [LEN_W-1:0]      max_length_q;
	phase_t                phase_q, phase_d;
	logic [7:0]            held_q, held_d;
	logic [COUNT_BITS-1:0] count_q;
	logic                  dropped_q;

	hex_t                  hx_b, hx_h;
	logic [2:0][7:0]       cand;
	logic [1:0]            cn;
	logic                  do_plain;
	logic [2:0]            fits;
	logic [1:0]            k;
	logic                  drop;
	logic [CMP_W-1:0]      cnt_ext, len_ext;

	assign hx_b = hex_digit(in_byte);
	assign hx_h = hex_digit(held_q);

	always_comb begin
		cand = '0;
		cn = 2'd0;
		phase_d = PH_NONE;
		held_d = held_q;
		do_plain = 1'b0;
		case (phase_q)
			PH_PCT: begin
				if (hx_b.ok) begin
					phase_d = PH_DIGIT;
					held_d = in_byte;
				end else begin
					cand[0] = CHR_PCT;
					cn = 2'd1;
					do_plain = 1'b1;
				end
			end
			PH_DIGIT: begin
				if (hx_b.ok) begin
					cand[0] = {hx_h.val, hx_b.val};
					cn = 2'd1;
				end else begin
					cand[0] = CHR_PCT;
					cand[1] = held_q;
					cn = 2'd2;
					do_plain = 1'b1;
				end
			end
			default: do_plain = 1'b1;
		endcase
		if (do_plain) begin
			if (in_byte == CHR_PCT) begin
				phase_d = PH_PCT;
			end else begin
				cand[cn] = (in_byte == CHR_PLUS) ? CHR_SPACE : in_byte;
				cn = cn + 2'd1;
			end
		end
		// flush a pending escape literally at the end of the string
		if (in_last) begin
			if (phase_d == PH_PCT) begin
				cand[cn] = CHR_PCT;
				cn = cn + 2'd1;
			end else if (phase_d == PH_DIGIT) begin
				cand[cn] = CHR_PCT;
				cand[2'(cn + 2'd1)] = held_d;
				cn = cn + 2'd2;
			end
		end
	end

	assign cnt_ext = CMP_W'(count_q);
	assign len_ext = CMP_W'(max_length_q);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fits[i] = (2'(i) < cn) && (cnt_ext + CMP_W'(i) < len_ext)
				&& (cnt_ext + CMP_W'(i) < CNT_MAX);
		end
		k = fits[2] ? 2'd3 : (fits[1] ? 2'd2 : (fits[0] ? 2'd1 : 2'd0));
		drop = (cn > k);
	end

	always_comb begin
		gq_wr.bytes = cand;
		gq_wr.num = (k == 2'd0) ? 2'd1 : k;
		gq_wr.has_byte = (k != 2'd0);
		gq_wr.last = in_last;
		gq_wr.trunc = dropped_q | drop;
	end

	// drop requests that yield nothing unless they close the string
	assign gq_push = accept && ((k != 2'd0) || in_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= LEN_RESET;
		end else if (cfg_valid) begin
			max_length_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NONE;
			held_q <= 8'd0;
			count_q <= '0;
			dropped_q <= 1'b0;
		end else if (accept) begin
			if (in_last) begin
				phase_q <= PH_NONE;
				held_q <= 8'd0;
				count_q <= '0;
				dropped_q <= 1'b0;
			end else begin
				phase_q <= phase_d;
				held_q <= held_d;
				count_q <= count_q + COUNT_BITS'(k);
				dropped_q <= dropped_q | drop;
			end
		end
	end

endmodule

// ===== sv/upd_gq.sv =====
// Short queue of result groups between the front and back ends.
module upd_gq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  upd_pkg::group_t wr,
	input  logic            pop,
	output upd_pkg::group_t rd,
	output logic            full,
	output logic            empty
);
	import upd_pkg::*;

	group_t             mem [GQ_DEPTH];
	logic [GQ_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [GQ_AW:0]     cnt_q;
	logic               do_push, do_pop;

	assign full = (cnt_q == (GQ_AW+1)'(GQ_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rd = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (GQ_AW+1)'(do_push) - (GQ_AW+1)'(do_pop);
		end
	end

endmodule

// ===== sv/upd_back.sv =====
// Back end: unpacks one group at a time into single results for the reader.
module upd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  upd_pkg::group_t gq_rd,
	input  logic            gq_empty,
	output logic            gq_pop,
	input  logic            pop,
	output logic            empty,
	output logic [7:0]      out_byte,
	output logic            has_byte,
	output logic            out_last,
	output logic            truncated
);
	import upd_pkg::*;

	group_t     cur_q;
	logic       cur_valid_q;
	logic [1:0] idx_q;
	logic       at_end;
	logic       taken;

	assign at_end = (idx_q == 2'(cur_q.num - 2'd1));
	assign taken = pop && cur_valid_q;
	// refill as soon as the held group is gone or its final result leaves
	assign gq_pop = !gq_empty && (!cur_valid_q || (taken && at_end));

	assign empty = !cur_valid_q;
	assign out_byte = cur_q.has_byte ? cur_q.bytes[idx_q] : 8'd0;
	assign has_byte = cur_q.has_byte;
	assign out_last = cur_q.last && at_end;
	assign truncated = cur_q.trunc;

	always_ff @(posedge clk) begin
		if (gq_pop) begin
			cur_q <= gq_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q <= 2'd0;
		end else if (gq_pop) begin
			cur_valid_q <= 1'b1;
			idx_q <= 2'd0;
		end else if (taken) begin
			if (at_end) begin
				cur_valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

// ===== sv/url_percent_decoder.sv =====
// Top level of the streaming URL percent decoder.
//
// Takes one encoded byte per cycle: push with full low. Each byte decodes into zero to three
// results (a broken escape is replayed literally, and the last byte flushes any held '%' and
// digit); a string that ends with nothing emitted gives one end-only result with has_byte low.
// The front end decides a byte's results and applies the max_length limit in the cycle it is
// accepted, and parks them as one group in a four-entry queue; the back end hands them out one
// per pop. A result is registered in the group queue and then in the back end before it can be
// popped. Input sustains one byte per cycle as long as the reader pops as many results as arrive;
// full rises only when the group queue is full. max_length is written through cfg_valid/cfg_ready,
// always ready, and should only change while no string is in flight.
`include "url_percent_decoder_defines.svh"

module url_percent_decoder #(
	parameter int COUNT_BITS = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [7:0]                in_byte,
	input  logic                      in_last,
	output logic                      empty,
	input  logic                      pop,
	output logic [7:0]                out_byte,
	output logic                      has_byte,
	output logic                      out_last,
	output logic                      truncated,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [upd_pkg::LEN_W-1:0] cfg_data
);
	import upd_pkg::*;

	group_t gq_wr, gq_rd;
	logic   gq_push, gq_pop, gq_full, gq_empty;
	logic   accept;

	assign cfg_ready = 1'b1;
	assign full = gq_full;
	assign accept = push && !gq_full;

	upd_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.in_byte(in_byte),
		.in_last(in_last),
		.cfg_valid(cfg_valid),
		.cfg_data(cfg_data),
		.gq_push(gq_push),
		.gq_wr(gq_wr)
	);

	upd_gq u_gq (
		.clk(clk),
		.arst_n(arst_n),
		.push(gq_push),
		.wr(gq_wr),
		.pop(gq_pop),
		.rd(gq_rd),
		.full(gq_full),
		.empty(gq_empty)
	);

	upd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.gq_rd(gq_rd),
		.gq_empty(gq_empty),
		.gq_pop(gq_pop),
		.pop(pop),
		.empty(empty),
		.out_byte(out_byte),
		.has_byte(has_byte),
		.out_last(out_last),
		.truncated(truncated)
	);

	`UPD_ASSERT_IMP(a_marker_is_last, clk, arst_n, !empty && !has_byte, out_last && out_byte == 8'd0, "end-only result must close the string")
	`UPD_ASSERT_IMP(a_no_push_when_full, clk, arst_n, gq_push, !gq_full, "group pushed into a full queue")
	`UPD_ASSERT_IMP(a_group_not_empty, clk, arst_n, gq_pop, gq_rd.num != 2'd0, "group with no results reached the back end")
	`UPD_ASSERT_NXT(a_refill_visible, clk, arst_n, gq_pop, !empty, "loaded group not presented")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the streaming URL percent decoder.
module testbench;
	import upd_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic       last;
		logic       trunc;
	} result_t;

	typedef struct packed {
		logic [7:0] b;
		logic       l;
	} raw_t;

	// Tracks the decoder's state and the decoded bytes still owed by it.
	class decode_scoreboard;
		logic [LEN_W-1:0] limit;
		phase_t           phase;
		logic [7:0]       held;
		logic [11:0]      count;
		logic             dropped;
		result_t          expected_q[$];
		result_t          step_q[$];
		int               errors;
		int               n_requests;
		int               n_strings;
		int               n_results;
		int               n_markers;
		int               n_trunc;

		function new();
			limit = LEN_RESET;
			phase = PH_NONE;
			held = 8'h00;
			count = '0;
			dropped = 1'b0;
			errors = 0;
			n_requests = 0;
			n_strings = 0;
			n_results = 0;
			n_markers = 0;
			n_trunc = 0;
		endfunction

		function bit hex_value(input logic [7:0] c, output logic [3:0] v);
			v = 4'h0;
			if (c >= "0" && c <= "9") begin
				v = 4'(c - "0");
				return 1'b1;
			end
			if (c >= "a" && c <= "f") begin
				v = 4'(c - "a" + 10);
				return 1'b1;
			end
			if (c >= "A" && c <= "F") begin
				v = 4'(c - "A" + 10);
				return 1'b1;
			end
			return 1'b0;
		endfunction

		// Emit within the length limit; the count saturates below all ones.
		function void put_byte(input logic [7:0] b);
			result_t r;
			if (count < limit && count != 12'hFFF) begin
				r.data = b;
				r.has = 1'b1;
				r.last = 1'b0;
				r.trunc = 1'b0;
				step_q.push_back(r);
				count = count + 12'd1;
			end else begin
				dropped = 1'b1;
			end
		endfunction

		function void plain_byte(input logic [7:0] b);
			if (b == CHR_PCT)
				phase = PH_PCT;
			else if (b == CHR_PLUS)
				put_byte(CHR_SPACE);
			else
				put_byte(b);
		endfunction

		function void note_request(input logic [7:0] b, input logic l);
			logic [3:0] hi;
			logic [3:0] lo;
			result_t    r;
			step_q.delete();
			n_requests++;
			case (phase)
				PH_PCT: begin
					if (hex_value(b, lo)) begin
						held = b;
						phase = PH_DIGIT;
					end else begin
						phase = PH_NONE;
						put_byte(CHR_PCT);
						plain_byte(b);
					end
				end
				PH_DIGIT: begin
					phase = PH_NONE;
					if (hex_value(b, lo)) begin
						void'(hex_value(held, hi));
						put_byte({hi, lo});
					end else begin
						put_byte(CHR_PCT);
						put_byte(held);
						plain_byte(b);
					end
				end
				default: plain_byte(b);
			endcase
			if (l) begin
				// flush a pending escape literally
				if (phase == PH_PCT) begin
					put_byte(CHR_PCT);
				end else if (phase == PH_DIGIT) begin
					put_byte(CHR_PCT);
					put_byte(held);
				end
				if (step_q.size() == 0) begin
					r = '0;
					step_q.push_back(r);
				end
				step_q[step_q.size()-1].last = 1'b1;
				n_strings++;
			end
			foreach (step_q[i]) begin
				step_q[i].trunc = dropped;
				expected_q.push_back(step_q[i]);
			end
			if (l) begin
				phase = PH_NONE;
				held = 8'h00;
				count = '0;
				dropped = 1'b0;
			end
		endfunction

		function void report_field(input string name, input logic [7:0] want,
				input logic [7:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(input logic [7:0] data, input logic has, input logic last,
				input logic trunc);
			result_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, actual byte %h has %b last %b trunc %b",
					$time, data, has, last, trunc);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			n_results++;
			if (!has)
				n_markers++;
			if (trunc)
				n_trunc++;
			report_field("out_byte", want.data, data);
			report_field("has_byte", 8'(want.has), 8'(has));
			report_field("out_last", 8'(want.last), 8'(last));
			report_field("truncated", 8'(want.trunc), 8'(trunc));
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             push = 1'b0;
	logic             full;
	logic [7:0]       in_byte = 8'h00;
	logic             in_last = 1'b0;
	logic             empty;
	logic             pop = 1'b0;
	logic [7:0]       out_byte;
	logic             has_byte;
	logic             out_last;
	logic             truncated;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [LEN_W-1:0] cfg_data = '0;

	decode_scoreboard sb = new();
	int               send_idle_pct = 0;
	int               recv_stall_pct = 0;
	int               n_cfg = 0;

	url_percent_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.has_byte  (has_byte),
		.out_last  (out_last),
		.truncated (truncated),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		pop <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
	end

	// Predict on each accepted request, check each popped result.
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				sb.note_request(in_byte, in_last);
			if (pop && !empty)
				sb.check_result(out_byte, has_byte, out_last, truncated);
		end
	end

	task automatic send_item(input logic [7:0] b, input logic l);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		in_byte <= b;
		in_last <= l;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic send_text(input string t);
		for (int i = 0; i < t.len(); i++)
			send_item(t[i], i == t.len() - 1);
	endtask

	task automatic drain();
		int waited;
		waited = 0;
		push <= 1'b0;
		while (sb.expected_q.size() != 0 && waited < 40000) begin
			@(posedge clk);
			waited++;
		end
		if (sb.expected_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, sb.expected_q.size());
			sb.errors += sb.expected_q.size();
			sb.expected_q.delete();
		end
		// let a request that owes nothing finish
		repeat (6) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LEN_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		sb.limit = v;
		n_cfg++;
	endtask

	function automatic logic [7:0] hex_char();
		int v;
		v = $urandom_range(15);
		if (v < 10)
			return 8'("0" + v);
		return $urandom_range(1) ? 8'("a" + v - 10) : 8'("A" + v - 10);
	endfunction

	function automatic logic [7:0] non_hex_char();
		logic [7:0] c;
		logic [3:0] v;
		do
			c = 8'($urandom_range(255));
		while (sb.hex_value(c, v));
		return c;
	endfunction

	// Random mix of printable bytes, well-formed escapes, plus signs, broken escapes and noise.
	function automatic void build_string(ref raw_t s[$]);
		int tokens;
		int roll;
		s.delete();
		tokens = $urandom_range(1, 6);
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(1, 8))
				s.push_back('{8'($urandom_range(255)), 1'b0});
		end else begin
			repeat (tokens) begin
				roll = $urandom_range(99);
				if (roll < 30) begin
					s.push_back('{8'($urandom_range(32, 126)), 1'b0});
				end else if (roll < 50) begin
					s.push_back('{CHR_PCT, 1'b0});
					s.push_back('{hex_char(), 1'b0});
					s.push_back('{hex_char(), 1'b0});
				end else if (roll < 58) begin
					s.push_back('{CHR_PLUS, 1'b0});
				end else if (roll < 70) begin
					s.push_back('{CHR_PCT, 1'b0});
					if ($urandom_range(1))
						s.push_back('{hex_char(), 1'b0});
					s.push_back('{non_hex_char(), 1'b0});
				end else if (roll < 88) begin
					s.push_back('{8'($urandom_range(255)), 1'b0});
				end else begin
					s.push_back('{CHR_PCT, 1'b0});
					if ($urandom_range(1))
						s.push_back('{hex_char(), 1'b0});
				end
			end
		end
		s[s.size()-1].l = 1'b1;
	endfunction

	task automatic run_phase(input logic [LEN_W-1:0] lim, input int sidle, input int rstall,
			input int n_items);
		raw_t s[$];
		int   sent;
		sent = 0;
		drain();
		write_limit(lim);
		send_idle_pct = sidle;
		recv_stall_pct = rstall;
		while (sent < n_items) begin
			build_string(s);
			foreach (s[i])
				send_item(s[i].b, s[i].l);
			sent += s.size();
		end
		push <= 1'b0;
	endtask

	initial begin
		#4_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: plus, escapes in both cases, broken escapes, flushes, zero bytes
		write_limit(12'hFFF);
		send_text("a+%41%6f");
		send_text("%z%4g%");
		send_item(8'h00, 1'b0);
		send_item(8'h80, 1'b0);
		send_text("%00%A");
		drain();
		// limit reached, then a string that emits nothing
		write_limit(12'd2);
		send_text("%41bc");
		drain();
		write_limit(12'd0);
		send_text("q%");

		run_phase(12'hFFF, 0, 0, 60);
		run_phase(12'd1, 56, 0, 60);
		run_phase(12'($urandom_range(2, 9)), 0, 56, 60);
		run_phase(12'($urandom_range(3, 12)), 33, 33, 60);
		run_phase(12'($urandom_range(1, 4095)), 56, 56, 40);

		drain();
		repeat (10) @(posedge clk);

		$display("Covered %0d strings, %0d bytes in, %0d results out (%0d end markers, %0d truncated)",
			sb.n_strings, sb.n_requests, sb.n_results, sb.n_markers, sb.n_trunc);
		$display("Used %0d max_length writes from 0 to 4095 under mixed idle and stall patterns",
			n_cfg);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
